/* design/dem_surface_normal_slope_core_macros.svh */
// Assertion macros shared by the checker of the surface normal and slope core.
`ifndef DEM_SURFACE_NORMAL_SLOPE_CORE_MACROS_SVH
`define DEM_SURFACE_NORMAL_SLOPE_CORE_MACROS_SVH

// Same-cycle implication.
`define DSN_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define DSN_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/dsn_pkg.sv */
// Types, constants and the arctangent table of the surface normal and slope core.
`timescale 1ns / 1ps
`default_nettype none
package dsn_pkg;

   localparam int MaxCols = 4096;
   localparam int ColW    = $clog2(MaxCols);
   localparam int CountW  = ColW + 1;
   localparam int RowW    = 16;
   localparam int ElevW   = 32;
   localparam int EntryW  = ElevW + 1;
   localparam int InvW    = 32;
   localparam int CsrIdxW = 2;

   localparam logic [CsrIdxW-1:0] CSR_COLUMN_COUNT = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_ROW_COUNT    = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_INV_TWO_DX   = 2'd2;
   localparam logic [CsrIdxW-1:0] CSR_INV_TWO_DY   = 2'd3;

   localparam int DivDendW = 46;
   localparam int DivSorW  = 32;
   localparam int DivQW    = 17;

   localparam int CordicSteps = 20;

   typedef struct packed {
      logic signed [ElevW-1:0] elevation;
      logic                    elevation_void;
      logic                    flush;
   } req_type;

   typedef struct packed {
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic [14:0]        normal_z;
      logic [13:0]        slope_centideg;
      logic               cell_void;
      logic               last_of_frame;
   } rsp_type;

   typedef struct packed {
      logic                start;
      logic [DivDendW-1:0] dividend;
      logic [DivSorW-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DivQW-1:0] quotient;
   } div_rsp_type;

   // atan(2^-i) in micro-degrees
   function automatic logic [26:0] atan_udeg(input logic [4:0] idx);
      logic [26:0] v;
      case (idx)
         5'd0:    v = 27'd45000000;
         5'd1:    v = 27'd26565051;
         5'd2:    v = 27'd14036243;
         5'd3:    v = 27'd7125016;
         5'd4:    v = 27'd3576334;
         5'd5:    v = 27'd1789911;
         5'd6:    v = 27'd895174;
         5'd7:    v = 27'd447614;
         5'd8:    v = 27'd223811;
         5'd9:    v = 27'd111906;
         5'd10:   v = 27'd55953;
         5'd11:   v = 27'd27976;
         5'd12:   v = 27'd13988;
         5'd13:   v = 27'd6994;
         5'd14:   v = 27'd3497;
         5'd15:   v = 27'd1749;
         5'd16:   v = 27'd874;
         5'd17:   v = 27'd437;
         5'd18:   v = 27'd219;
         5'd19:   v = 27'd109;
         default: v = 27'd0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

/* design/dsn_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module dsn_ram #(
   parameter int Width = 33,
   parameter int Depth = 4096,
   localparam int AddrW = $clog2(Depth)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AddrW-1:0] wr_addr,
   input  wire logic [Width-1:0] wr_data,
   input  wire logic [AddrW-1:0] rd_addr,
   output logic      [Width-1:0] rd_data
);

   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

/* design/dsn_div.sv */
// Restoring divider, one quotient bit per cycle; quotient must fit DivQW bits.
`timescale 1ns / 1ps
`default_nettype none
module dsn_div (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire dsn_pkg::div_req_type div_req,
   output dsn_pkg::div_rsp_type   div_rsp
);

   logic                           busy_ff;
   logic                           done_ff;
   logic [4:0]                     cnt_ff;
   logic [dsn_pkg::DivSorW-1:0]    rem_ff;
   logic [dsn_pkg::DivSorW-1:0]    sor_ff;
   logic [dsn_pkg::DivQW-1:0]      quo_ff;
   logic [dsn_pkg::DivSorW:0]      trial;
   logic                           fits;

   assign trial = {rem_ff, quo_ff[dsn_pkg::DivQW-1]};
   assign fits  = trial >= {1'b0, sor_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= !div_req.start && busy_ff && (cnt_ff == 5'(dsn_pkg::DivQW - 1));
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'(dsn_pkg::DivQW - 1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         // high part is already below the divisor for an in-range quotient
         rem_ff <= dsn_pkg::DivSorW'(div_req.dividend[dsn_pkg::DivDendW-1:dsn_pkg::DivQW]);
         quo_ff <= div_req.dividend[dsn_pkg::DivQW-1:0];
         sor_ff <= div_req.divisor;
      end else if (busy_ff) begin
         rem_ff <= fits ? dsn_pkg::DivSorW'(trial - {1'b0, sor_ff})
                        : trial[dsn_pkg::DivSorW-1:0];
         quo_ff <= {quo_ff[dsn_pkg::DivQW-2:0], fits};
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule
`default_nettype wire

/* design/dem_surface_normal_slope_core.sv */
// Surface normal and slope of a raster elevation stream, top level.
// Elevation cells enter in raster order; each cell of a row is emitted when the
// cell below it arrives, and flush beats drain the last row. Two line stores
// (middle and upper row) live in RAMs; cell beats before the drain read and
// write them back, drain beats only read them. Cells of the first row and
// flushes that arrive before the last row is in give no result. Void cells
// skip the datapath. Other cells pass through one sequential datapath: a
// shared 32x32 multiplier, a one-bit-per-cycle normalizing shift, two 32-step
// square roots, a 20-step CORDIC, three 17-step divisions for the normal and
// a reciprocal multiply that rounds the slope to centidegrees. The next beat
// is taken as soon as a result sits in the output register, even if that
// result has not yet been taken. There is no clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none
module dem_surface_normal_slope_core (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire dsn_pkg::req_type            req_payload,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output dsn_pkg::rsp_type                 rsp_payload,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [dsn_pkg::CsrIdxW-1:0] csr_index,
   input  wire logic [31:0]                 csr_wdata
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_RD1      = 4'd1;
   localparam logic [3:0] S_RD2      = 4'd2;
   localparam logic [3:0] S_PREP     = 4'd3;
   localparam logic [3:0] S_MULX     = 4'd4;
   localparam logic [3:0] S_MULY     = 4'd5;
   localparam logic [3:0] S_MAXM     = 4'd6;
   localparam logic [3:0] S_NORM     = 4'd7;
   localparam logic [3:0] S_SQ       = 4'd8;
   localparam logic [3:0] S_SQRT     = 4'd9;
   localparam logic [3:0] S_CORDIC   = 4'd10;
   localparam logic [3:0] S_DIV_GO   = 4'd11;
   localparam logic [3:0] S_DIV_WAIT = 4'd12;
   localparam logic [3:0] S_OUT      = 4'd13;

   localparam logic [1:0] DIV_X     = 2'd0;
   localparam logic [1:0] DIV_Y     = 2'd1;
   localparam logic [1:0] DIV_Z     = 2'd2;

   localparam int ColW   = dsn_pkg::ColW;
   localparam int CountW = dsn_pkg::CountW;
   localparam int RowW   = dsn_pkg::RowW;
   localparam int EntryW = dsn_pkg::EntryW;
   localparam int ElevW  = dsn_pkg::ElevW;

   localparam logic [63:0] OneQ24 = 64'd1 << 24;
   localparam logic [63:0] SqrtTop = 64'd1 << 62;
   // ceil(2^41 / 10000): exact quotient for every reachable angle sum
   localparam logic [31:0] SlopeRecip = 32'd219902326;

   logic [3:0]              state_ff;

   // configuration
   logic [CountW-1:0]       col_count_ff;
   logic [RowW-1:0]         row_count_ff;
   logic [dsn_pkg::InvW-1:0] inv_dx_ff;
   logic [dsn_pkg::InvW-1:0] inv_dy_ff;

   // raster position and window
   logic [ColW-1:0]         col_pos_ff;
   logic [RowW-1:0]         row_pos_ff;
   logic [EntryW-1:0]       win_centre_ff;

   // beat context
   logic [EntryW-1:0]       smp_ff;
   logic [ColW-1:0]         c_ff;
   logic                    drain_ff;
   logic                    has_up_ff;
   logic                    has_left_ff;
   logic                    has_right_ff;
   logic                    last_ff;
   logic [EntryW-1:0]       centre_ff;
   logic [EntryW-1:0]       up_ff;
   logic [EntryW-1:0]       right_ff;

   // datapath
   logic                    void_ff;
   logic                    negx_ff;
   logic                    negy_ff;
   logic [31:0]             adx_ff;
   logic [31:0]             ady_ff;
   logic [63:0]             gx_ff;
   logic [63:0]             gy_ff;
   logic [63:0]             na_ff;
   logic [63:0]             nb_ff;
   logic [24:0]             nc_ff;
   logic [63:0]             m_ff;
   logic [1:0]              sq_k_ff;
   logic [63:0]             prod_ff;
   logic [63:0]             acc_ff;
   logic [63:0]             h2_ff;
   logic [63:0]             sv_ff;
   logic [63:0]             sr_ff;
   logic [63:0]             sbit_ff;
   logic                    sq_pass_ff;
   logic [31:0]             n_ff;
   logic                    hzero_ff;
   logic signed [35:0]      cx_ff;
   logic signed [35:0]      cy_ff;
   logic signed [28:0]      cz_ff;
   logic [4:0]              ci_ff;
   logic [1:0]              div_sel_ff;
   logic [dsn_pkg::DivQW-1:0] qx_ff;
   logic [dsn_pkg::DivQW-1:0] qy_ff;
   logic [dsn_pkg::DivQW-1:0] qz_ff;
   logic [dsn_pkg::DivQW-1:0] qs_ff;

   logic                    rsp_valid_ff;
   dsn_pkg::rsp_type        rsp_ff;

   // ---------------------------------------------------------------- geometry
   logic [CountW-1:0]       cols;
   logic [RowW-1:0]         rows;
   logic [ColW-1:0]         c_eff;
   logic [CountW-1:0]       c_next;
   logic                    draining;
   logic                    accept;
   logic                    row_end;

   always_comb begin
      if (col_count_ff == '0) begin
         cols = CountW'(1);
      end else if (col_count_ff > CountW'(dsn_pkg::MaxCols)) begin
         cols = CountW'(dsn_pkg::MaxCols);
      end else begin
         cols = col_count_ff;
      end
   end

   assign rows     = (row_count_ff == '0) ? RowW'(1) : row_count_ff;
   assign c_eff    = ({1'b0, col_pos_ff} >= cols) ? '0 : col_pos_ff;
   assign c_next   = {1'b0, c_eff} + CountW'(1);
   assign row_end  = c_next == cols;
   assign draining = row_pos_ff >= rows;
   assign req_stall = state_ff != S_IDLE;
   assign accept   = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // ---------------------------------------------------------------- line stores
   logic              mid_wr_en;
   logic [ColW-1:0]   mid_rd_addr;
   logic [EntryW-1:0] mid_rd_data;
   logic              up_wr_en;
   logic [ColW-1:0]   up_rd_addr;
   logic [EntryW-1:0] up_rd_data;
   logic [ColW-1:0]   wr_addr;
   logic [EntryW-1:0] mid_wr_data;
   logic              first_row_beat;

   assign first_row_beat = accept && !draining && !req_payload.flush && row_pos_ff == '0;
   assign mid_wr_en   = first_row_beat || (state_ff == S_RD2 && !drain_ff);
   assign up_wr_en    = state_ff == S_RD2 && !drain_ff;
   assign wr_addr     = (state_ff == S_IDLE) ? c_eff : c_ff;
   assign mid_wr_data = (state_ff == S_IDLE)
                        ? {req_payload.elevation_void, req_payload.elevation} : smp_ff;
   assign mid_rd_addr = (state_ff == S_IDLE) ? c_eff : c_ff + ColW'(1);
   assign up_rd_addr  = (state_ff == S_IDLE) ? c_eff : c_ff;

   dsn_ram #(.Width(EntryW), .Depth(dsn_pkg::MaxCols)) u_mid_ram (
      .clock   (clock),
      .wr_en   (mid_wr_en),
      .wr_addr (wr_addr),
      .wr_data (mid_wr_data),
      .rd_addr (mid_rd_addr),
      .rd_data (mid_rd_data)
   );

   dsn_ram #(.Width(EntryW), .Depth(dsn_pkg::MaxCols)) u_up_ram (
      .clock   (clock),
      .wr_en   (up_wr_en),
      .wr_addr (wr_addr),
      .wr_data (centre_ff),
      .rd_addr (up_rd_addr),
      .rd_data (up_rd_data)
   );

   // ---------------------------------------------------------------- gradients
   logic [EntryW-1:0]       left_e;
   logic [EntryW-1:0]       down_e;
   logic [ElevW-1:0]        zc;
   logic [ElevW-1:0]        zl;
   logic [ElevW-1:0]        zr;
   logic [ElevW-1:0]        zu;
   logic [ElevW-1:0]        zd;
   logic signed [ElevW:0]   dxz;
   logic signed [ElevW:0]   dyz;
   logic [ElevW:0]          dxz_abs;
   logic [ElevW:0]          dyz_abs;

   assign left_e  = has_left_ff ? win_centre_ff : centre_ff;
   assign down_e  = drain_ff ? centre_ff : smp_ff;
   assign zc      = centre_ff[ElevW-1:0];
   assign zl      = left_e[ElevW]   ? zc : left_e[ElevW-1:0];
   assign zr      = right_ff[ElevW] ? zc : right_ff[ElevW-1:0];
   assign zu      = up_ff[ElevW]    ? zc : up_ff[ElevW-1:0];
   assign zd      = down_e[ElevW]   ? zc : down_e[ElevW-1:0];
   assign dxz     = $signed({zr[ElevW-1], zr}) - $signed({zl[ElevW-1], zl});
   assign dyz     = $signed({zu[ElevW-1], zu}) - $signed({zd[ElevW-1], zd});
   assign dxz_abs = dxz[ElevW] ? 33'(-dxz) : 33'(dxz);
   assign dyz_abs = dyz[ElevW] ? 33'(-dyz) : 33'(dyz);

   // ---------------------------------------------------------------- shared multiplier
   logic [31:0] mul_a;
   logic [31:0] mul_b;
   logic [63:0] mul_p;
   logic [28:0] z_pos;

   assign z_pos  = cz_ff[28] ? '0 : cz_ff;

   always_comb begin
      case (state_ff)
         S_MULX:  begin mul_a = adx_ff; mul_b = inv_dx_ff; end
         S_MULY:  begin mul_a = ady_ff; mul_b = inv_dy_ff; end
         // rounded angle times the reciprocal of 10000
         S_CORDIC: begin mul_a = 32'(z_pos) + 32'd5000; mul_b = SlopeRecip; end
         default: begin
            case (sq_k_ff)
               2'd0:    begin mul_a = na_ff[31:0]; mul_b = na_ff[31:0]; end
               2'd1:    begin mul_a = nb_ff[31:0]; mul_b = nb_ff[31:0]; end
               default: begin mul_a = 32'(nc_ff); mul_b = 32'(nc_ff); end
            endcase
         end
      endcase
   end

   assign mul_p = {32'b0, mul_a} * {32'b0, mul_b};

   // ---------------------------------------------------------------- max, sqrt, cordic
   logic [63:0] m_gxy;
   logic [63:0] sq_t;
   logic signed [35:0] cx_sh;
   logic signed [35:0] cy_sh;
   logic signed [28:0] atan_v;

   assign m_gxy  = (gx_ff > gy_ff) ? gx_ff : gy_ff;
   assign sq_t   = sr_ff + sbit_ff;
   assign cx_sh  = cx_ff >>> ci_ff;
   assign cy_sh  = cy_ff >>> ci_ff;
   assign atan_v = $signed({2'b00, dsn_pkg::atan_udeg(ci_ff)});

   // ---------------------------------------------------------------- divider
   dsn_pkg::div_req_type div_req;
   dsn_pkg::div_rsp_type div_rsp;
   logic [31:0]          n_safe;

   assign n_safe = (n_ff == '0) ? 32'd1 : n_ff;

   always_comb begin
      div_req.start   = state_ff == S_DIV_GO;
      div_req.divisor = n_safe;
      case (div_sel_ff)
         DIV_X:   div_req.dividend = 46'({na_ff[29:0], 15'b0}) + 46'(n_safe[31:1]);
         DIV_Y:   div_req.dividend = 46'({nb_ff[29:0], 15'b0}) + 46'(n_safe[31:1]);
         default: div_req.dividend = 46'({nc_ff, 15'b0}) + 46'(n_safe[31:1]);
      endcase
   end

   dsn_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // ---------------------------------------------------------------- control
   logic out_free;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         col_count_ff  <= CountW'(1024);
         row_count_ff  <= RowW'(1024);
         inv_dx_ff     <= 32'd32768;
         inv_dy_ff     <= 32'd32768;
         col_pos_ff    <= '0;
         row_pos_ff    <= '0;
         win_centre_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= (state_ff == S_OUT && out_free) || (rsp_valid_ff && rsp_stall);

         case (state_ff)
            S_IDLE: begin
               if (accept && (draining || !req_payload.flush)) begin
                  if (row_end) begin
                     col_pos_ff <= '0;
                     row_pos_ff <= draining ? '0 : row_pos_ff + RowW'(1);
                  end else begin
                     col_pos_ff <= c_next[ColW-1:0];
                  end
                  if (draining || row_pos_ff != '0) begin
                     state_ff <= S_RD1;
                  end
               end
            end
            S_RD1:  state_ff <= S_RD2;
            S_RD2:  state_ff <= S_PREP;
            S_PREP: begin
               win_centre_ff <= centre_ff;
               state_ff      <= centre_ff[ElevW] ? S_OUT : S_MULX;
            end
            S_MULX: state_ff <= S_MULY;
            S_MULY: state_ff <= S_MAXM;
            S_MAXM: state_ff <= S_NORM;
            S_NORM: begin
               if (m_ff[63:30] == '0) begin
                  state_ff <= S_SQ;
               end
            end
            S_SQ: begin
               if (sq_k_ff == 2'd3) begin
                  state_ff <= S_SQRT;
               end
            end
            S_SQRT: begin
               if (sbit_ff == '0 && sq_pass_ff) begin
                  state_ff <= S_CORDIC;
               end
            end
            S_CORDIC: begin
               if (ci_ff == 5'(dsn_pkg::CordicSteps)) begin
                  state_ff <= S_DIV_GO;
               end
            end
            S_DIV_GO: state_ff <= S_DIV_WAIT;
            S_DIV_WAIT: begin
               if (div_rsp.done) begin
                  state_ff <= (div_sel_ff == DIV_Z) ? S_OUT : S_DIV_GO;
               end
            end
            S_OUT: begin
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase

         // geometry write restarts the frame
         if (csr_valid && csr_ready) begin
            case (csr_index)
               dsn_pkg::CSR_COLUMN_COUNT: begin
                  col_count_ff  <= csr_wdata[CountW-1:0];
                  col_pos_ff    <= '0;
                  row_pos_ff    <= '0;
                  win_centre_ff <= '0;
               end
               dsn_pkg::CSR_ROW_COUNT: begin
                  row_count_ff  <= csr_wdata[RowW-1:0];
                  col_pos_ff    <= '0;
                  row_pos_ff    <= '0;
                  win_centre_ff <= '0;
               end
               dsn_pkg::CSR_INV_TWO_DX: inv_dx_ff <= csr_wdata;
               dsn_pkg::CSR_INV_TWO_DY: inv_dy_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // ---------------------------------------------------------------- datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            smp_ff       <= {req_payload.elevation_void, req_payload.elevation};
            c_ff         <= c_eff;
            drain_ff     <= draining;
            has_left_ff  <= c_eff != '0;
            has_right_ff <= c_next < cols;
            has_up_ff    <= draining ? (rows >= RowW'(2)) : (row_pos_ff >= RowW'(2));
            last_ff      <= draining && row_end;
         end
         S_RD1: begin
            centre_ff <= mid_rd_data;
            up_ff     <= has_up_ff ? up_rd_data : mid_rd_data;
         end
         S_RD2: begin
            right_ff <= has_right_ff ? mid_rd_data : centre_ff;
         end
         S_PREP: begin
            void_ff <= centre_ff[ElevW];
            negx_ff <= dxz > 33'sd0;
            negy_ff <= dyz > 33'sd0;
            adx_ff  <= dxz_abs[31:0];
            ady_ff  <= dyz_abs[31:0];
            qx_ff   <= '0;
            qy_ff   <= '0;
            qz_ff   <= '0;
            qs_ff   <= '0;
         end
         S_MULX: gx_ff <= mul_p;
         S_MULY: gy_ff <= mul_p;
         S_MAXM: begin
            na_ff   <= gx_ff;
            nb_ff   <= gy_ff;
            nc_ff   <= 25'(OneQ24);
            m_ff    <= (m_gxy < OneQ24) ? OneQ24 : m_gxy;
            sq_k_ff <= '0;
         end
         S_NORM: begin
            if (m_ff[63:30] != '0) begin
               na_ff <= na_ff >> 1;
               nb_ff <= nb_ff >> 1;
               nc_ff <= nc_ff >> 1;
               m_ff  <= m_ff >> 1;
            end
         end
         S_SQ: begin
            // product is registered, so it arrives in the cycle after its operand select
            prod_ff <= mul_p;
            sq_k_ff <= sq_k_ff + 2'd1;
            case (sq_k_ff)
               2'd1:    acc_ff <= prod_ff;
               2'd2:    acc_ff <= acc_ff + prod_ff;
               2'd3: begin
                  h2_ff      <= acc_ff;
                  sv_ff      <= acc_ff + prod_ff;
                  sr_ff      <= '0;
                  sbit_ff    <= SqrtTop;
                  sq_pass_ff <= 1'b0;
               end
               default: ;
            endcase
         end
         S_SQRT: begin
            if (sbit_ff == '0) begin
               if (!sq_pass_ff) begin
                  n_ff       <= sr_ff[31:0];
                  sv_ff      <= h2_ff;
                  sr_ff      <= '0;
                  sbit_ff    <= SqrtTop;
                  sq_pass_ff <= 1'b1;
               end else begin
                  hzero_ff <= sr_ff == '0;
                  cx_ff    <= $signed(36'(nc_ff));
                  cy_ff    <= $signed(36'(sr_ff[31:0]));
                  cz_ff    <= '0;
                  ci_ff    <= '0;
               end
            end else begin
               if (sv_ff >= sq_t) begin
                  sv_ff <= sv_ff - sq_t;
                  sr_ff <= (sr_ff >> 1) + sbit_ff;
               end else begin
                  sr_ff <= sr_ff >> 1;
               end
               sbit_ff <= sbit_ff >> 2;
            end
         end
         S_CORDIC: begin
            if (ci_ff != 5'(dsn_pkg::CordicSteps)) begin
               if (cy_ff > 36'sd0) begin
                  cx_ff <= cx_ff + cy_sh;
                  cy_ff <= cy_ff - cx_sh;
                  cz_ff <= cz_ff + atan_v;
               end else begin
                  cx_ff <= cx_ff - cy_sh;
                  cy_ff <= cy_ff + cx_sh;
                  cz_ff <= cz_ff - atan_v;
               end
               ci_ff <= ci_ff + 5'd1;
            end else begin
               div_sel_ff <= DIV_X;
               qs_ff      <= hzero_ff ? '0 : mul_p[57:41];
            end
         end
         S_DIV_WAIT: begin
            if (div_rsp.done) begin
               case (div_sel_ff)
                  DIV_X:   qx_ff <= div_rsp.quotient;
                  DIV_Y:   qy_ff <= div_rsp.quotient;
                  default: qz_ff <= div_rsp.quotient;
               endcase
               div_sel_ff <= div_sel_ff + 2'd1;
            end
         end
         default: ;
      endcase
   end

   // ---------------------------------------------------------------- result register
   logic [14:0] cx_q;
   logic [14:0] cy_q;
   logic [14:0] cz_q;
   logic [13:0] cs_q;

   assign cx_q = (qx_ff > 17'd32767) ? 15'd32767 : qx_ff[14:0];
   assign cy_q = (qy_ff > 17'd32767) ? 15'd32767 : qy_ff[14:0];
   assign cz_q = (qz_ff > 17'd32767) ? 15'd32767 : qz_ff[14:0];
   assign cs_q = (qs_ff > 17'd9000)  ? 14'd9000  : qs_ff[13:0];

   always_ff @(posedge clock) begin
      if (state_ff == S_OUT && out_free) begin
         rsp_ff.normal_x       <= negx_ff ? 16'(-{1'b0, cx_q}) : {1'b0, cx_q};
         rsp_ff.normal_y       <= negy_ff ? 16'(-{1'b0, cy_q}) : {1'b0, cy_q};
         rsp_ff.normal_z       <= cz_q;
         rsp_ff.slope_centideg <= cs_q;
         rsp_ff.cell_void      <= void_ff;
         rsp_ff.last_of_frame  <= last_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
`default_nettype wire

/* design/dsn_checker.sv */
// Port-level checker for the surface normal and slope core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "dem_surface_normal_slope_core_macros.svh"
module dsn_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire dsn_pkg::rsp_type rsp_payload
);

   `DSN_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload), "stalled result beat changed")

   `DSN_ASSERT_IMPLY(a_void_zero, clock, reset, rsp_valid && rsp_payload.cell_void, rsp_payload.normal_x == 16'sd0 && rsp_payload.normal_y == 16'sd0 && rsp_payload.normal_z == 15'd0 && rsp_payload.slope_centideg == 14'd0, "void cell with nonzero result")

   `DSN_ASSERT_IMPLY(a_slope_range, clock, reset, rsp_valid, rsp_payload.slope_centideg <= 14'd9000, "slope above 90 degrees")

   `DSN_ASSERT_IMPLY(a_normal_range, clock, reset, rsp_valid, rsp_payload.normal_x != 16'sh8000 && rsp_payload.normal_y != 16'sh8000, "normal component out of Q1.15 range")

endmodule

bind dem_surface_normal_slope_core dsn_checker u_dsn_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
`default_nettype wire
